// File: src/cfp_pkg.sv
`default_nettype none
package cfp_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_TOOBIG  = 2'd3;

  localparam logic [31:0] PKT_MAGIC   = 32'hA5A5A5A5;
  localparam logic [7:0]  TYPE_HEADER = 8'h01;
  localparam logic [7:0]  TYPE_CHUNK  = 8'h02;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam int          HDR_BYTES   = 13;

  localparam logic [9:0] CHUNK_LEN_RESET = 10'd512;
  localparam logic       ADDR_CHUNK_LEN  = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_HEADER = 6'b000100,
    S_FILL   = 6'b001000,
    S_SEND   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic div_start;  // latch length/size, begin division
    logic div_step;
    logic open_frame;
    logic push;
    logic emit;       // advance emit position
    logic emit_last;
    logic chunk_done;
    logic load_out;
    logic [1:0] status;
    logic out_valid;
    logic from_chunk; // selects chunk packet, else header packet
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic too_big;
    logic fill_full;  // push would overflow store
    logic chunk_end;  // this push closes the chunk
    logic hdr_last;
    logic pkt_last;
    logic bytes_zero;
  } stat_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/cfp_ctrl.sv
`default_nettype none
module cfp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_go_i,
  input  wire logic [1:0]    cmd_i,
  input  wire logic          out_busy_i,
  input  wire cfp_pkg::stat_t stat_i,
  output cfp_pkg::ctrl_t     ctrl_o,
  output logic               in_ready_o
);

  cfp_pkg::state_e state_q, state_d;

  assign in_ready_o = !out_busy_i && (state_q != cfp_pkg::S_DIV);

  always_comb begin
    ctrl_o = '0;
    state_d = state_q;
    if (state_q == cfp_pkg::S_DIV) begin
      ctrl_o.div_step = 1'b1;
      if (stat_i.div_done) begin
        ctrl_o.load_out = 1'b1;
        if (stat_i.too_big) begin
          ctrl_o.status = cfp_pkg::ST_TOOBIG;
          state_d = cfp_pkg::S_IDLE;
        end else begin
          ctrl_o.open_frame = 1'b1;
          state_d = cfp_pkg::S_HEADER;
        end
      end
    end else if (in_go_i) begin
      ctrl_o.load_out = 1'b1;
      unique case (cmd_i)
        cfp_pkg::CMD_START: begin
          if (state_q == cfp_pkg::S_IDLE) begin
            ctrl_o.load_out = 1'b0;
            ctrl_o.div_start = 1'b1;
            state_d = cfp_pkg::S_DIV;
          end else begin
            ctrl_o.status = cfp_pkg::ST_REFUSED;
          end
        end
        cfp_pkg::CMD_PUSH: begin
          if (state_q != cfp_pkg::S_FILL || stat_i.fill_full) begin
            ctrl_o.status = cfp_pkg::ST_REFUSED;
          end else begin
            ctrl_o.push = 1'b1;
            if (stat_i.chunk_end) state_d = cfp_pkg::S_SEND;
          end
        end
        cfp_pkg::CMD_PULL: begin
          if (state_q == cfp_pkg::S_HEADER) begin
            ctrl_o.out_valid = 1'b1;
            ctrl_o.emit = 1'b1;
            if (stat_i.hdr_last) begin
              ctrl_o.emit_last = 1'b1;
              state_d = stat_i.bytes_zero ? cfp_pkg::S_IDLE : cfp_pkg::S_FILL;
            end
          end else if (state_q == cfp_pkg::S_SEND) begin
            ctrl_o.out_valid = 1'b1;
            ctrl_o.emit = 1'b1;
            ctrl_o.from_chunk = 1'b1;
            if (stat_i.pkt_last) begin
              ctrl_o.emit_last = 1'b1;
              ctrl_o.chunk_done = 1'b1;
              state_d = stat_i.bytes_zero ? cfp_pkg::S_IDLE : cfp_pkg::S_FILL;
            end
          end else begin
            ctrl_o.status = cfp_pkg::ST_EMPTY;
          end
        end
        default: ctrl_o.status = cfp_pkg::ST_REFUSED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_div_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cfp_pkg::S_DIV |-> !in_ready_o) else $error("accept during divide");
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |=> state_q == cfp_pkg::S_DIV) else $error("start lost");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |-> !ctrl_o.load_out) else $error("start result early");

endmodule
`default_nettype wire

// File: src/cfp_dp.sv
`default_nettype none
module cfp_dp #(
  parameter int MAX_CHUNK = 512
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfp_pkg::ctrl_t ctrl_i,
  input  wire logic [9:0]     chunk_len_i,
  input  wire logic [23:0]    frame_bytes_i,
  input  wire logic [7:0]     data_byte_i,
  output cfp_pkg::stat_t      stat_o,
  output logic [7:0]          byte_o,
  output logic                eop_o
);

  localparam int AW = $clog2(MAX_CHUNK);
  localparam int FW = $clog2(MAX_CHUNK + 1);
  localparam int EW = $clog2(MAX_CHUNK + cfp_pkg::HDR_BYTES + 1);
  localparam int LW = (FW > 10) ? FW : 10;

  logic [7:0] store_q [MAX_CHUNK];
  logic [7:0] rd_q;

  logic [FW-1:0] fill_q;
  logic [31:0]   crc_q;
  logic [15:0]   chunk_num_q, chunk_tot_q;
  logic [23:0]   left_q, size_q;
  logic [EW-1:0] pos_q;
  logic [LW-1:0] len_q;

  // restoring divider: one quotient bit per cycle, 24 steps
  logic [23:0] rem_q, quo_q;
  logic [23:0] dvd_q;
  logic [4:0]  cnt_q;
  logic [24:0] trial;
  logic [LW-1:0] len_sel;
  logic [9:0]  cl0;

  assign cl0 = (chunk_len_i == 10'd0) ? 10'd1 : chunk_len_i;
  always_comb begin
    if ({{(LW-10){1'b0}}, cl0} > LW'(MAX_CHUNK)) len_sel = LW'(MAX_CHUNK);
    else len_sel = {{(LW-10){1'b0}}, cl0};
  end

  assign trial = {rem_q, dvd_q[23]} - {{(25-LW){1'b0}}, len_q};

  logic [24:0] cnt_full;
  assign cnt_full = {1'b0, quo_q} + {24'd0, rem_q != 24'd0};

  assign stat_o.div_done  = (cnt_q == 5'd24);
  assign stat_o.too_big   = cnt_full > 25'd65535;
  assign stat_o.fill_full = fill_q >= FW'(MAX_CHUNK);
  assign stat_o.chunk_end = ({{(LW-FW){1'b0}}, fill_q} + LW'(1) >= len_q) ||
                            (left_q == 24'd1);
  assign stat_o.hdr_last  = pos_q == EW'(cfp_pkg::HDR_BYTES - 1);
  assign stat_o.pkt_last  = {1'b0, pos_q} == {1'b0, EW'(fill_q)} + (EW+1)'(cfp_pkg::HDR_BYTES - 1);
  assign stat_o.bytes_zero = left_q == 24'd0;

  function automatic logic [7:0] le(input logic [31:0] v, input logic [1:0] i);
    return v[8*i +: 8];
  endfunction

  logic [7:0] head_b;
  logic [31:0] crc_out;
  assign crc_out = crc_q ^ cfp_pkg::CRC_INIT;
  always_comb begin
    if (pos_q < EW'(4)) head_b = le(cfp_pkg::PKT_MAGIC, pos_q[1:0]);
    else if (pos_q == EW'(4)) head_b = ctrl_i.from_chunk ? cfp_pkg::TYPE_CHUNK
                                                        : cfp_pkg::TYPE_HEADER;
    else if (!ctrl_i.from_chunk) begin
      if (pos_q < EW'(9)) head_b = le({8'd0, size_q}, 2'(pos_q - EW'(5)));
      else if (pos_q < EW'(11)) head_b = le(32'(len_q), 2'(pos_q - EW'(9)));
      else head_b = le({16'd0, chunk_tot_q}, 2'(pos_q - EW'(11)));
    end else begin
      if (pos_q < EW'(7)) head_b = le({16'd0, chunk_num_q}, 2'(pos_q - EW'(5)));
      else if (pos_q < EW'(9)) head_b = le(32'(fill_q), 2'(pos_q - EW'(7)));
      else head_b = le(crc_out, 2'(pos_q - EW'(9)));
    end
  end

  // store read address runs one beat ahead of the pull
  logic [EW-1:0] pos_n;
  logic [AW-1:0] raddr;
  assign pos_n = ctrl_i.emit ? (ctrl_i.emit_last ? '0 : pos_q + EW'(1)) : pos_q;
  assign raddr = AW'(pos_n - EW'(cfp_pkg::HDR_BYTES));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) store_q[fill_q[AW-1:0]] <= data_byte_i;
    rd_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; crc_q <= cfp_pkg::CRC_INIT; chunk_num_q <= '0; chunk_tot_q <= '0;
      left_q <= '0; size_q <= '0; pos_q <= '0; len_q <= LW'(1);
      rem_q <= '0; quo_q <= '0; dvd_q <= '0; cnt_q <= '0;
      byte_o <= '0; eop_o <= 1'b0;
    end else begin
      if (ctrl_i.div_start) begin
        len_q <= len_sel; dvd_q <= frame_bytes_i; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
        size_q <= frame_bytes_i;
      end else if (ctrl_i.div_step && cnt_q != 5'd24) begin
        if (!trial[24]) rem_q <= trial[23:0];
        else rem_q <= {rem_q[22:0], dvd_q[23]};
        quo_q <= {quo_q[22:0], !trial[24]};
        dvd_q <= {dvd_q[22:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
      end
      if (ctrl_i.open_frame) begin
        chunk_tot_q <= cnt_full[15:0]; left_q <= size_q; chunk_num_q <= '0;
        fill_q <= '0; crc_q <= cfp_pkg::CRC_INIT; pos_q <= '0;
      end
      if (ctrl_i.push) begin
        fill_q <= fill_q + FW'(1);
        crc_q  <= cfp_pkg::crc_feed(crc_q, data_byte_i);
        left_q <= left_q - 24'd1;
      end
      if (ctrl_i.emit) pos_q <= pos_n;
      if (ctrl_i.chunk_done) begin
        chunk_num_q <= chunk_num_q + 16'd1; fill_q <= '0; crc_q <= cfp_pkg::CRC_INIT;
      end
      if (ctrl_i.load_out) begin
        byte_o <= !ctrl_i.out_valid ? 8'd0 :
                  (ctrl_i.from_chunk && pos_q >= EW'(cfp_pkg::HDR_BYTES)) ? rd_q : head_b;
        eop_o  <= ctrl_i.emit_last;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> fill_q < FW'(MAX_CHUNK)) else $error("store overflow");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0) else $error("zero chunk length");
  a_chunk_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.chunk_done |=> fill_q == '0 && crc_q == cfp_pkg::CRC_INIT) else $error("clear");

endmodule
`default_nettype wire

// File: src/chunked_frame_packetizer_crc32.sv
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid_i/stall_o | cmd_i, frame_bytes_i, data_byte_i
// out     | out | out_valid_o/stall_i| out_valid_flag_o, out_byte_o, end_of_packet_o, status_o
// cfg     | in  | APB psel/penable   | chunk_length at address 0
// Push and pull each load one result per beat into the output register.
// A start runs a 24-step shift-subtract divider for the chunk count.
// The chunk store is a 1-port-write, 1-port-read RAM read one beat ahead of the pull.
// Reset is asynchronous; the store needs no clearing.
// Input is held off while a result waits under out stall or the divider runs.
`default_nettype none
module chunked_frame_packetizer_crc32 #(
  parameter int MAX_CHUNK = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [23:0] frame_bytes_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_flag_o,
  output logic [7:0]       out_byte_o,
  output logic             end_of_packet_o,
  output logic [1:0]       status_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfp_pkg::ctrl_t ctrl;
  cfp_pkg::stat_t stat;
  logic [9:0] chunk_len_q;
  logic in_ready, in_go, busy_q;

  assign pready = 1'b1;
  assign prdata = {22'd0, chunk_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chunk_len_q <= cfp_pkg::CHUNK_LEN_RESET;
    else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[1] ==
             !cfp_pkg::ADDR_CHUNK_LEN)
      chunk_len_q <= pwdata[9:0];
  end

  assign in_stall_o = !in_ready;
  assign in_go = in_valid_i && in_ready;

  cfp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_go_i(in_go), .cmd_i, .out_busy_i(busy_q && out_stall_i),
    .stat_i(stat), .ctrl_o(ctrl), .in_ready_o(in_ready)
  );

  cfp_dp #(.MAX_CHUNK(MAX_CHUNK)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .chunk_len_i(chunk_len_q),
    .frame_bytes_i, .data_byte_i, .stat_o(stat), .byte_o(out_byte_o), .eop_o(end_of_packet_o)
  );

  logic flag_q;
  logic [1:0] st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; flag_q <= 1'b0; st_q <= cfp_pkg::ST_OK;
    end else begin
      if (ctrl.load_out) begin
        busy_q <= 1'b1; flag_q <= ctrl.out_valid; st_q <= ctrl.status;
      end else if (!out_stall_i) busy_q <= 1'b0;
    end
  end

  assign out_valid_o = busy_q;
  assign out_valid_flag_o = flag_q;
  assign status_o = st_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |-> !ctrl.load_out) else $error("result overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> busy_q) else $error("result dropped");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> $stable(out_byte_o)) else $error("payload moved");

endmodule
`default_nettype wire
